// ===== sv/tsa_pkg.sv =====
// Shared types and constants for the tagged slot allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package tsa_pkg;

    // Field widths of the channels and of the count register.
    localparam int CNT_W     = 7;
    localparam int SLOT_W    = 6;
    localparam int TAG_IN_W  = 16;
    localparam int TAG_OUT_W = 15;

    // Largest table that a six-bit slot index can address.
    localparam int SLOT_LIMIT = 64;

    // Defaults for the top-level parameters.
    localparam int MAX_SLOTS_DEF = 64;
    localparam int TAG_BITS_DEF  = 15;

    typedef enum logic [1:0] {
        ACT_ALLOC_FIRST = 2'd0,
        ACT_ALLOC_NAMED = 2'd1,
        ACT_RELEASE     = 2'd2,
        ACT_QUERY       = 2'd3
    } t_action;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic read_slot;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_end;
        logic out_free;
    } t_stat;

endpackage

// ===== sv/tagged_slot_allocator.sv =====
// Top level of the tagged slot allocator: controller plus datapath.
// Depends on tsa_pkg, tsa_ctrl and tsa_dpath.
//
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_action, i_owner_tag, i_slot_index
// out       output     o_out_valid / i_out_ready o_status, o_slot_taken, o_tag_out,
//                                                o_tag_valid, o_used_slots, o_free_slots
// cfg       input      i_cfg_we (no wait)        i_cfg_wdata (slot count)
//
// An allocation goes through a scan, then the commit:
// the tag-uniqueness check and the first-free search share one serial scan
// that reads one tag memory entry per cycle through its single read port.
// A release or a query does one memory read, then the commit.
// Reset is synchronous and active low; it frees all slots at once through
// the busy flip-flops, so there is no clearing pass. A finished result waits
// in the output register while the next item is taken in; that item holds
// at its commit step until the output register is free.
module tagged_slot_allocator import tsa_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int TAG_BITS  = TAG_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CNT_W-1:0]            i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_action,
    input  logic signed [TAG_IN_W-1:0]  i_owner_tag,
    input  logic [SLOT_W-1:0]           i_slot_index,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_status,
    output logic [SLOT_W-1:0]           o_slot_taken,
    output logic [TAG_OUT_W-1:0]        o_tag_out,
    output logic                        o_tag_valid,
    output logic [CNT_W-1:0]            o_used_slots,
    output logic [CNT_W-1:0]            o_free_slots
);

    t_cmd    cmd;
    t_stat   stat;
    t_action action;

    // The action field covers all four codes, so the cast is lossless.
    assign action = t_action'(i_action);

    // The controller sequences each item: accept, scan or read, then commit.
    tsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (action),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath holds the table, does the scan and registers the result.
    tsa_dpath #(
        .MAX_SLOTS (MAX_SLOTS),
        .TAG_BITS  (TAG_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_action     (action),
        .i_owner_tag  (i_owner_tag),
        .i_slot_index (i_slot_index),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_slot_taken (o_slot_taken),
        .o_tag_out    (o_tag_out),
        .o_tag_valid  (o_tag_valid),
        .o_used_slots (o_used_slots),
        .o_free_slots (o_free_slots)
    );

endmodule

// ===== sv/tsa_ctrl.sv =====
// Controller state machine of the tagged slot allocator.
// Depends on tsa_pkg; drives the datapath through t_cmd and watches t_stat.
module tsa_ctrl import tsa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_action i_action,
    output logic    o_in_ready,
    input  t_stat   i_stat,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_action inside {ACT_ALLOC_FIRST, ACT_ALLOC_NAMED}) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.read_slot = 1'b1;
                n_state         = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/tsa_dpath.sv =====
// Datapath of the tagged slot allocator: tag memory, busy bits, counts,
// the serial tag scan and the output register. Depends on tsa_pkg.
module tsa_dpath import tsa_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int TAG_BITS  = TAG_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CNT_W-1:0]            i_cfg_wdata,
    input  t_action                     i_action,
    input  logic signed [TAG_IN_W-1:0]  i_owner_tag,
    input  logic [SLOT_W-1:0]           i_slot_index,
    input  t_cmd                        i_cmd,
    output t_stat                       o_stat,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_status,
    output logic [SLOT_W-1:0]           o_slot_taken,
    output logic [TAG_OUT_W-1:0]        o_tag_out,
    output logic                        o_tag_valid,
    output logic [CNT_W-1:0]            o_used_slots,
    output logic [CNT_W-1:0]            o_free_slots
);

    localparam int DEPTH      = (MAX_SLOTS < SLOT_LIMIT) ? MAX_SLOTS : SLOT_LIMIT;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int STORE_BITS = (TAG_BITS < TAG_OUT_W) ? TAG_BITS : TAG_OUT_W;

    // Table state.
    logic [STORE_BITS-1:0] r_mem [DEPTH];
    logic [STORE_BITS-1:0] r_rd_data;
    logic [DEPTH-1:0]      r_busy;
    logic [CNT_W-1:0]      r_slot_count;
    logic [CNT_W-1:0]      r_used;

    // Item being worked on.
    t_action               r_action;
    logic [TAG_IN_W-1:0]   r_tag;
    logic [SLOT_W-1:0]     r_slot;

    // Scan state.
    logic [CNT_W-1:0]      r_scan;
    logic                  r_cmp_valid;
    logic                  r_cmp_busy;
    logic                  r_held;
    logic                  r_found;
    logic [ADDR_W-1:0]     r_pick;

    // Output register.
    logic                  r_out_valid;
    logic                  r_status;
    logic [SLOT_W-1:0]     r_taken;
    logic [TAG_OUT_W-1:0]  r_tag_out;
    logic                  r_tag_valid;
    logic [CNT_W-1:0]      r_used_out;
    logic [CNT_W-1:0]      r_free_out;

    logic [ADDR_W-1:0]     scan_a;
    logic [ADDR_W-1:0]     slot_a;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  in_range;
    logic                  tag_ok;
    logic                  alloc_ok;
    logic                  grant;
    logic [ADDR_W-1:0]     grant_a;
    logic                  hit;
    logic [CNT_W-1:0]      n_used;
    logic                  n_status;
    logic [SLOT_W-1:0]     n_taken;
    logic [TAG_OUT_W-1:0]  n_tag_out;
    logic                  n_tag_valid;
    logic                  n_set_busy;
    logic                  n_clr_busy;
    logic [CNT_W-1:0]      cfg_count;

    assign scan_a   = r_scan[ADDR_W-1:0];
    assign slot_a   = r_slot[ADDR_W-1:0];
    assign rd_addr  = i_cmd.scan_step ? scan_a : slot_a;
    assign in_range = ({1'b0, r_slot} < r_slot_count);
    assign cfg_count = (i_cfg_wdata > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : i_cfg_wdata;

    assign o_stat.scan_end = (r_scan >= r_slot_count);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // Refusal and grant logic, evaluated in the commit cycle.
    assign tag_ok   = !r_tag[TAG_IN_W-1] &&
                      ((r_tag[TAG_OUT_W-1:0] >> STORE_BITS) == '0);
    assign alloc_ok = tag_ok && (r_used < r_slot_count) && !r_held;
    assign hit      = in_range && r_busy[slot_a];

    always_comb begin
        n_used      = r_used;
        n_status    = 1'b1;
        n_taken     = '0;
        n_tag_out   = '0;
        n_tag_valid = 1'b0;
        n_set_busy  = 1'b0;
        n_clr_busy  = 1'b0;
        grant       = 1'b0;
        grant_a     = slot_a;
        case (r_action)
            ACT_ALLOC_FIRST: begin
                grant   = alloc_ok && r_found;
                grant_a = r_pick;
            end
            ACT_ALLOC_NAMED: begin
                grant   = alloc_ok && in_range && !r_busy[slot_a];
                grant_a = slot_a;
            end
            ACT_RELEASE: begin
                if (hit) begin
                    n_status    = 1'b0;
                    n_tag_out   = TAG_OUT_W'(r_rd_data);
                    n_tag_valid = 1'b1;
                    n_clr_busy  = 1'b1;
                    n_used      = r_used - CNT_W'(1);
                end
            end
            ACT_QUERY: begin
                if (hit) begin
                    n_status    = 1'b0;
                    n_tag_out   = TAG_OUT_W'(r_rd_data);
                    n_tag_valid = 1'b1;
                end
            end
            default: begin
                n_status = 1'b1;
            end
        endcase
        if (grant) begin
            n_status   = 1'b0;
            n_taken    = SLOT_W'(grant_a);
            n_set_busy = 1'b1;
            n_used     = r_used + CNT_W'(1);
        end
    end

    // Tag memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && n_set_busy) begin
            r_mem[grant_a] <= r_tag[STORE_BITS-1:0];
        end
        if (i_cmd.scan_step || i_cmd.read_slot) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Item, scan and output payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_tag    <= i_owner_tag;
            r_slot   <= i_slot_index;
            r_scan   <= '0;
            r_held   <= 1'b0;
            r_found  <= 1'b0;
            r_pick   <= '0;
        end else begin
            if (i_cmd.scan_step) begin
                r_scan     <= r_scan + CNT_W'(1);
                r_cmp_busy <= r_busy[scan_a];
                if (!r_busy[scan_a] && !r_found) begin
                    r_found <= 1'b1;
                    r_pick  <= scan_a;
                end
            end
            if (r_cmp_valid && r_cmp_busy && (r_rd_data == r_tag[STORE_BITS-1:0])) begin
                r_held <= 1'b1;
            end
        end
        if (i_cmd.commit) begin
            r_status    <= n_status;
            r_taken     <= n_taken;
            r_tag_out   <= n_tag_out;
            r_tag_valid <= n_tag_valid;
            r_used_out  <= n_used;
            r_free_out  <= r_slot_count - n_used;
        end
    end

    // Control state: busy bits, counts, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= '0;
            r_used       <= '0;
            r_slot_count <= '0;
            r_out_valid  <= 1'b0;
            r_cmp_valid  <= 1'b0;
        end else begin
            r_cmp_valid <= i_cmd.scan_step;
            if (i_cfg_we) begin
                r_slot_count <= cfg_count;
                r_busy       <= '0;
                r_used       <= '0;
            end else if (i_cmd.commit) begin
                r_used <= n_used;
                if (n_set_busy) begin
                    r_busy[grant_a] <= 1'b1;
                end
                if (n_clr_busy) begin
                    r_busy[slot_a] <= 1'b0;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_slot_taken = r_taken;
    assign o_tag_out    = r_tag_out;
    assign o_tag_valid  = r_tag_valid;
    assign o_used_slots = r_used_out;
    assign o_free_slots = r_free_out;

endmodule

// ===== sv/tsa_checker.sv =====
// Port-level assertions for the tagged slot allocator, bound to the top level.
// Depends on tsa_pkg and on the tagged_slot_allocator port list.
module tsa_checker import tsa_pkg::*; (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_status,
    input logic [SLOT_W-1:0]           o_slot_taken,
    input logic [TAG_OUT_W-1:0]        o_tag_out,
    input logic                        o_tag_valid,
    input logic [CNT_W-1:0]            o_used_slots,
    input logic [CNT_W-1:0]            o_free_slots
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status) &&
            $stable(o_slot_taken) && $stable(o_tag_out) && $stable(o_used_slots)))
        else $error("result changed while stalled");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transfer taken while an item is in flight");

    // Occupied plus free never exceeds the largest table.
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (({1'b0, o_used_slots} + {1'b0, o_free_slots}) <= 8'(SLOT_LIMIT)))
        else $error("slot counts out of range");

    // A refused or empty result carries no slot and no tag.
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_slot_taken == '0 && !o_tag_valid &&
            o_tag_out == '0))
        else $error("refused result carries data");

    // A tag is reported only by a successful release or query.
    a_tag_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tag_valid) |-> (!o_status && o_slot_taken == '0))
        else $error("tag reported with a failed or allocating result");

endmodule

bind tagged_slot_allocator tsa_checker u_tsa_checker (.*);

// ===== tb/tb_tagged_slot_allocator.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for tagged_slot_allocator: directed and random slot actions
// across several slot-count settings, checked against an in-bench table predictor.
// Depends on tsa_pkg and the tagged_slot_allocator RTL.
module tb_tagged_slot_allocator;
    import tsa_pkg::*;

    // Longest stretch of cycles without any transfer before the run is declared hung.
    // The worst correct case is the long receiver hold-off plus a full
    // 64-slot allocation scan, a sender gap and a few receiver stalls.
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int ITEMS_PER_PHASE  = 50;
    localparam int DRAIN_CYCLES     = 80;

    // One input item as it is offered on the input channel.
    typedef struct packed {
        t_action                     action;
        logic signed [TAG_IN_W-1:0]  owner_tag;
        logic [SLOT_W-1:0]           slot_index;
    } slot_item_t;

    // One result item with every output field of the block.
    typedef struct packed {
        logic                  status;
        logic [SLOT_W-1:0]     slot_taken;
        logic [TAG_OUT_W-1:0]  tag_out;
        logic                  tag_valid;
        logic [CNT_W-1:0]      used_slots;
        logic [CNT_W-1:0]      free_slots;
    } slot_result_t;

    // Every input of the block starts at a known value.
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CNT_W-1:0]           i_cfg_wdata = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [1:0]                 i_action = '0;
    logic signed [TAG_IN_W-1:0] i_owner_tag = '0;
    logic [SLOT_W-1:0]          i_slot_index = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic                       o_status;
    logic [SLOT_W-1:0]          o_slot_taken;
    logic [TAG_OUT_W-1:0]       o_tag_out;
    logic                       o_tag_valid;
    logic [CNT_W-1:0]           o_used_slots;
    logic [CNT_W-1:0]           o_free_slots;

    tagged_slot_allocator uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_owner_tag  (i_owner_tag),
        .i_slot_index (i_slot_index),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_slot_taken (o_slot_taken),
        .o_tag_out    (o_tag_out),
        .o_tag_valid  (o_tag_valid),
        .o_used_slots (o_used_slots),
        .o_free_slots (o_free_slots)
    );

    // Clock: 4 ns period.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: the slot table as the block should hold it.
    // ------------------------------------------------------------------
    logic [TAG_OUT_W-1:0] held_tag [SLOT_LIMIT];
    bit                   slot_held [SLOT_LIMIT];
    int                   used_total = 0;
    int                   table_size = 0;   // slot count after saturation
    int                   grant_count = 0;
    int                   refusal_count = 0;

    // Items waiting for the sender, and predicted results waiting for the output.
    slot_item_t   action_q [$];
    slot_result_t outcome_q [$];

    // Transfer counters, each written by one process only.
    int sent_total = 0;     // items placed on the input channel (sender)
    int taken_total = 0;    // input transfers seen (checker)
    int results_seen = 0;   // output transfers seen (checker)
    int error_count = 0;
    int stall_cycles = 0;
    int phase_total = 0;

    // A count write frees the whole table. Values beyond the table saturate.
    task automatic load_slot_count(input logic [CNT_W-1:0] value);
        table_size = (value > SLOT_LIMIT) ? SLOT_LIMIT : int'(value);
        used_total = 0;
        for (int i = 0; i < SLOT_LIMIT; i++) begin
            slot_held[i] = 1'b0;
        end
    endtask

    // Applies one action to the predicted table and returns the result it must produce.
    function automatic slot_result_t apply_slot_action(input t_action act,
                                                       input logic signed [TAG_IN_W-1:0] tag,
                                                       input logic [SLOT_W-1:0] idx);
        slot_result_t r;
        bit in_range;
        bit tag_ok;
        bit tag_taken;
        bit grant;
        int pick;
        int i;
        r = '0;
        r.status = 1'b1;
        in_range = idx < table_size;
        if (act == ACT_ALLOC_FIRST || act == ACT_ALLOC_NAMED) begin
            // The tag must be non-negative and not held by any slot in use.
            tag_taken = 1'b0;
            for (i = 0; i < table_size; i++) begin
                if (slot_held[i] && held_tag[i] == tag[TAG_OUT_W-1:0]) begin
                    tag_taken = 1'b1;
                end
            end
            tag_ok = !tag[TAG_IN_W-1] && used_total < table_size && !tag_taken;
            grant = 1'b0;
            pick = 0;
            if (tag_ok && act == ACT_ALLOC_FIRST) begin
                for (i = 0; i < table_size && !grant; i++) begin
                    if (!slot_held[i]) begin
                        pick = i;
                        grant = 1'b1;
                    end
                end
            end else if (tag_ok && in_range && !slot_held[idx]) begin
                pick = int'(idx);
                grant = 1'b1;
            end
            if (grant) begin
                slot_held[pick] = 1'b1;
                held_tag[pick] = tag[TAG_OUT_W-1:0];
                used_total++;
                r.status = 1'b0;
                r.slot_taken = SLOT_W'(pick);
                grant_count++;
            end else begin
                refusal_count++;
            end
        end else if (in_range && slot_held[idx]) begin
            // Release and query both report the tag; release also frees the slot.
            r.status = 1'b0;
            r.tag_out = held_tag[idx];
            r.tag_valid = 1'b1;
            if (act == ACT_RELEASE) begin
                slot_held[idx] = 1'b0;
                used_total--;
            end
        end
        r.used_slots = CNT_W'(used_total);
        r.free_slots = CNT_W'(table_size - used_total);
        return r;
    endfunction

    // Builds one random item. Most slot indexes fall inside the table and half the tags
    // come from a small pool, so that duplicate tags, full tables and releases of
    // held slots happen often; the rest covers every bit of both fields.
    function automatic slot_item_t random_slot_item(input int size);
        slot_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            it.action = ACT_ALLOC_FIRST;
        end else if (pick < 60) begin
            it.action = ACT_ALLOC_NAMED;
        end else if (pick < 80) begin
            it.action = ACT_RELEASE;
        end else begin
            it.action = ACT_QUERY;
        end
        if (size > 0 && $urandom_range(0, 4) != 0) begin
            it.slot_index = SLOT_W'($urandom_range(0, size - 1));
        end else begin
            it.slot_index = SLOT_W'($urandom_range(0, 63));
        end
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            it.owner_tag = TAG_IN_W'($urandom_range(0, 15));
        end else if (pick < 7) begin
            it.owner_tag = TAG_IN_W'($urandom_range(0, 32767));
        end else if (pick < 9) begin
            it.owner_tag = TAG_IN_W'($urandom);
        end else begin
            case ($urandom_range(0, 3))
                0: it.owner_tag = 16'sh0000;
                1: it.owner_tag = 16'sh7FFF;
                2: it.owner_tag = 16'sh8000;
                default: it.owner_tag = 16'shFFFF;
            endcase
        end
        return it;
    endfunction

    task automatic push_item(input t_action act, input int tag, input int idx);
        slot_item_t it;
        it.action = act;
        it.owner_tag = TAG_IN_W'(tag);
        it.slot_index = SLOT_W'(idx);
        action_q.push_back(it);
    endtask

    // Prints one line per mismatch and counts it.
    task automatic flag_error(input string msg);
        error_count++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            flag_error($sformatf("result %0d field %s got %0h expected %0h",
                                 results_seen, name, got, want));
        end
    endtask

    // Returns once every queued item has been transferred and every predicted
    // result has arrived. Checked at the falling edge, when all counters are settled.
    task automatic wait_until_drained();
        while (action_q.size() != 0 || sent_total != taken_total || i_in_valid ||
               outcome_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // The count register is written only while the block is idle. Every item gives
    // a result, so a drained queue means the block is done; a few extra cycles let
    // its controller return to rest.
    task automatic program_slot_count(input int value);
        wait_until_drained();
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= CNT_W'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        phase_total++;
    endtask

    // ------------------------------------------------------------------
    // Sender: offers items from action_q in bursts of random length with
    // random gaps. An offered item stays on the port until its transfer.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;

    always @(negedge i_clk) begin : sender
        slot_item_t nxt;
        if (i_rst_n && (!i_in_valid || sent_total == taken_total)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (action_q.size() > 0) begin
                nxt = action_q.pop_front();
                i_in_valid <= 1'b1;
                i_action <= nxt.action;
                i_owner_tag <= nxt.owner_tag;
                i_slot_index <= nxt.slot_index;
                sent_total <= sent_total + 1;
                if (burst_left <= 1) begin
                    // A quarter of the bursts are followed by no gap at all.
                    burst_left <= $urandom_range(1, 16);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: switches between always ready, half ready and mostly stalled.
    // Once, after sixty results, it holds off for a long stretch while the
    // sender keeps offering, so the block fills up and stalls its input.
    // ------------------------------------------------------------------
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;
    int  ready_mode = 0;
    int  mode_left = 0;

    always @(negedge i_clk) begin : receiver
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && results_seen >= 60) begin
            long_hold_done <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(10, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checker: samples at the rising edge. Output transfers are compared with
    // the oldest prediction before the input transfer of the same edge adds
    // its own, so a stray result cannot match a brand-new prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        slot_result_t want;
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                load_slot_count(i_cfg_wdata);
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (outcome_q.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with nothing pending",
                                         results_seen));
                end else begin
                    want = outcome_q.pop_front();
                    check_field("status", 16'(o_status), 16'(want.status));
                    check_field("slot_taken", 16'(o_slot_taken), 16'(want.slot_taken));
                    check_field("tag_out", 16'(o_tag_out), 16'(want.tag_out));
                    check_field("tag_valid", 16'(o_tag_valid), 16'(want.tag_valid));
                    check_field("used_slots", 16'(o_used_slots), 16'(want.used_slots));
                    check_field("free_slots", 16'(o_free_slots), 16'(want.free_slots));
                end
                results_seen <= results_seen + 1;
            end
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                outcome_q.push_back(apply_slot_action(t_action'(i_action), i_owner_tag,
                                                      i_slot_index));
                taken_total <= taken_total + 1;
            end
        end
        // Watchdog: a long run of cycles without any transfer means the block hung.
        if (moved) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results still pending",
                     stall_cycles, outcome_q.size());
            $display("[tagged_slot_allocator] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed items, then random phases, one per
    // slot-count setting, the extremes and a saturating write among them.
    // ------------------------------------------------------------------
    int phase_counts [10] = '{127, 1, 5, 64, 0, 12, 3, 100, 8, 2};

    initial begin
        for (int i = 0; i < SLOT_LIMIT; i++) begin
            held_tag[i] = '0;
            slot_held[i] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // With the reset count of zero every allocation is refused and every
        // slot is out of range.
        push_item(ACT_ALLOC_FIRST, 1, 0);
        push_item(ACT_QUERY, 0, 0);

        // A four-slot table is small enough to walk through every refusal.
        program_slot_count(4);
        push_item(ACT_ALLOC_FIRST, 0, 0);         // lowest tag, takes slot 0
        push_item(ACT_ALLOC_FIRST, 32767, 0);     // highest tag, takes slot 1
        push_item(ACT_ALLOC_NAMED, 5, 3);         // named slot
        push_item(ACT_ALLOC_NAMED, 5, 2);         // tag already held
        push_item(ACT_ALLOC_NAMED, 7, 3);         // slot occupied
        push_item(ACT_ALLOC_NAMED, 7, 63);        // slot out of range
        push_item(ACT_ALLOC_FIRST, -1, 0);        // negative tag
        push_item(ACT_ALLOC_FIRST, -32768, 63);   // most negative tag
        push_item(ACT_ALLOC_FIRST, 32767, 0);     // duplicate of the highest tag
        push_item(ACT_ALLOC_FIRST, 9, 0);         // last free slot, table now full
        push_item(ACT_ALLOC_FIRST, 11, 0);        // table full
        push_item(ACT_ALLOC_NAMED, 12, 0);        // table full, named
        push_item(ACT_QUERY, 0, 1);               // held slot
        push_item(ACT_QUERY, 0, 63);              // out of range
        push_item(ACT_RELEASE, 0, 3);             // frees tag 5
        push_item(ACT_RELEASE, 0, 3);             // slot already free
        push_item(ACT_RELEASE, 0, 63);            // out of range
        push_item(ACT_QUERY, 0, 3);               // free slot
        push_item(ACT_ALLOC_NAMED, 5, 3);         // freed tag may be taken again

        foreach (phase_counts[p]) begin
            program_slot_count(phase_counts[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                action_q.push_back(random_slot_item(table_size));
            end
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items over %0d slot-count settings: %0d grants, %0d refused",
                 taken_total, phase_total, grant_count, refusal_count);
        $display("%0d results checked, %0d mismatches", results_seen, error_count);
        if (error_count == 0) begin
            $display("[tagged_slot_allocator] OK");
        end else begin
            $display("[tagged_slot_allocator] ERROR");
        end
        $finish;
    end

endmodule
